// ===== hw/rtl/tpd_pkg.sv =====
`timescale 1ns / 1ps
// tpd_pkg: shared types and constants of the threshold peak detector
// no dependencies; used by the cfg channel interface and all modules

package tpd_pkg;

  // configuration port layout
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int THRESHOLD_WIDTH = 15;
  localparam int LIMIT_WIDTH     = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLDOFF_LIMIT = 2'd1;

  // reset value of the holdoff limit register
  localparam logic [LIMIT_WIDTH-1:0] HOLDOFF_LIMIT_RESET = 16'd500;

  // detector mode codes
  localparam int MODE_WIDTH = 2;
  localparam logic [MODE_WIDTH-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_TRACK = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_HOLD  = 2'd2;

  // configuration as seen by the detector core
  typedef struct packed {
    logic [THRESHOLD_WIDTH-1:0] threshold;
    logic [LIMIT_WIDTH-1:0]     holdoff_limit;
  } cfg_t;

endpackage

// ===== hw/rtl/tpd_if.sv =====
`timescale 1ns / 1ps
// tpd_if: valid/ready channel interfaces of the threshold peak detector
// depends on tpd_pkg for the configuration port widths

interface tpd_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tpd_result_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
);
  logic                           valid;
  logic                           ready;
  logic                           detect;
  logic        [COUNT_WIDTH-1:0]  peak_offset;
  logic signed [SAMPLE_WIDTH-1:0] peak_level;

  modport source (output valid, output detect, output peak_offset, output peak_level,
                  input ready);
  modport sink (input valid, input detect, input peak_offset, input peak_level,
                output ready);
endinterface

interface tpd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tpd_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [tpd_pkg::CFG_DATA_WIDTH-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/tpd_cfg_regs.sv =====
`timescale 1ns / 1ps
// tpd_cfg_regs: threshold and holdoff limit registers
// depends on tpd_pkg and tpd_cfg_if

module tpd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tpd_cfg_if.sink        cfg,
  output tpd_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold     <= '0;
      regs.holdoff_limit <= tpd_pkg::HOLDOFF_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tpd_pkg::CFG_THRESHOLD: begin
          regs.threshold <= cfg.data[tpd_pkg::THRESHOLD_WIDTH-1:0];
        end
        tpd_pkg::CFG_HOLDOFF_LIMIT: begin
          regs.holdoff_limit <= cfg.data[tpd_pkg::LIMIT_WIDTH-1:0];
        end
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tpd_core.sv =====
`timescale 1ns / 1ps
// tpd_core: detector state and the one-sample mode update
// depends on tpd_pkg

module tpd_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  tpd_pkg::cfg_t                  cfg,
  output logic                           detect,
  output logic        [COUNT_WIDTH-1:0]  peak_offset,
  output logic signed [SAMPLE_WIDTH-1:0] peak_level
);

  localparam int CMP_WIDTH = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
  localparam int LIM_WIDTH = (COUNT_WIDTH > tpd_pkg::LIMIT_WIDTH) ?
                             COUNT_WIDTH : tpd_pkg::LIMIT_WIDTH;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [tpd_pkg::MODE_WIDTH-1:0] mode, mode_next;
  logic signed [SAMPLE_WIDTH-1:0] peak_value, peak_value_next;
  logic [COUNT_WIDTH-1:0]         peak_age, peak_age_next;
  logic [COUNT_WIDTH-1:0]         holdoff_count, holdoff_count_next;

  logic signed [CMP_WIDTH-1:0] sample_ext;
  logic signed [CMP_WIDTH-1:0] thr_neg;
  logic [LIM_WIDTH-1:0]        limit_ext;
  logic [COUNT_WIDTH-1:0]      limit;
  logic                        above, higher, is_track, is_hold;
  logic [COUNT_WIDTH-1:0]      age_inc;

  assign sample_ext = CMP_WIDTH'(sample);
  assign thr_neg    = $signed(CMP_WIDTH'(0) - CMP_WIDTH'(cfg.threshold));
  assign above      = sample_ext > thr_neg;
  assign higher     = sample > peak_value;
  assign is_track   = (mode == tpd_pkg::MODE_TRACK);
  assign is_hold    = (mode == tpd_pkg::MODE_HOLD);

  // limit clipped to the counter range so holdoff always ends
  assign limit_ext = LIM_WIDTH'(cfg.holdoff_limit);
  assign limit     = (limit_ext > LIM_WIDTH'(COUNT_MAX)) ? COUNT_MAX
                                                        : limit_ext[COUNT_WIDTH-1:0];

  assign age_inc = ((is_track || is_hold) && (peak_age != COUNT_MAX)) ?
                   peak_age + 1'b1 : peak_age;

  always_comb begin
    mode_next          = mode;
    peak_value_next    = peak_value;
    peak_age_next      = age_inc;
    holdoff_count_next = holdoff_count;
    detect             = 1'b0;
    peak_offset        = '0;
    peak_level         = '0;
    if (above || is_track) begin
      if (is_hold) begin
        holdoff_count_next = '0;
      end
      if (higher) begin
        mode_next       = tpd_pkg::MODE_TRACK;
        peak_value_next = sample;
        peak_age_next   = '0;
      end else if (above) begin
        mode_next = tpd_pkg::MODE_TRACK;
      end else if (holdoff_count < limit) begin
        // fell below level while tracking: first holdoff sample
        mode_next          = tpd_pkg::MODE_HOLD;
        holdoff_count_next = holdoff_count + 1'b1;
      end else begin
        // zero limit: declare right away
        detect             = 1'b1;
        peak_offset        = age_inc;
        peak_level         = peak_value;
        mode_next          = tpd_pkg::MODE_IDLE;
        peak_value_next    = SAMPLE_MIN;
        peak_age_next      = '0;
        holdoff_count_next = '0;
      end
    end else if (is_hold) begin
      if (holdoff_count < limit) begin
        holdoff_count_next = holdoff_count + 1'b1;
      end else begin
        detect             = 1'b1;
        peak_offset        = age_inc;
        peak_level         = peak_value;
        mode_next          = tpd_pkg::MODE_IDLE;
        peak_value_next    = SAMPLE_MIN;
        peak_age_next      = '0;
        holdoff_count_next = '0;
      end
    end else begin
      mode_next = tpd_pkg::MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tpd_pkg::MODE_IDLE;
      peak_value    <= SAMPLE_MIN;
      peak_age      <= '0;
      holdoff_count <= '0;
    end else if (step) begin
      mode          <= mode_next;
      peak_value    <= peak_value_next;
      peak_age      <= peak_age_next;
      holdoff_count <= holdoff_count_next;
    end
  end

endmodule

// ===== hw/rtl/threshold_peak_detector_holdoff.sv =====
`timescale 1ns / 1ps
// threshold_peak_detector_holdoff: top level with input and result registers
// depends on tpd_pkg, tpd_if, tpd_cfg_regs and tpd_core
//
//   channel  | dir | interface      | payload
//   ---------+-----+----------------+-------------------------------------
//   samples  | in  | tpd_sample_if  | sample
//   results  | out | tpd_result_if  | detect, peak_offset, peak_level
//   cfg      | in  | tpd_cfg_if     | index, data (threshold, holdoff_limit)
//
// one request in per cycle while results are taken, one result out per request;
// each passes the input register, then the result register; the mode update between them is a
// few compares and counter increments
// rst is synchronous and clears mode, counters and both valid flags, sets the peak to the
// most negative sample, threshold to zero and the holdoff limit to 500
// a stalled result holds; a new sample is still taken while the input stage is empty or
// can drain, so throughput stays one per cycle until both stages are full

module threshold_peak_detector_holdoff #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic          clk,
  input  logic          rst,
  tpd_sample_if.sink    samples,
  tpd_result_if.source  results,
  tpd_cfg_if.sink       cfg
);

  // configuration registers
  tpd_pkg::cfg_t regs;

  tpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input stage
  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  // result stage
  logic                           out_valid;
  logic                           out_detect;
  logic        [COUNT_WIDTH-1:0]  out_offset;
  logic signed [SAMPLE_WIDTH-1:0] out_level;

  // core results for the sample in the input stage
  logic                           core_detect;
  logic        [COUNT_WIDTH-1:0]  core_offset;
  logic signed [SAMPLE_WIDTH-1:0] core_level;

  logic out_free;   // result register can load this cycle
  logic advance;    // input stage moves into the result register

  assign out_free      = !out_valid || results.ready;
  assign advance       = in_valid && out_free;
  assign samples.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_sample <= samples.sample;
    end
  end

  // state update happens exactly when the sample leaves the input stage
  tpd_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .sample      (in_sample),
    .cfg         (regs),
    .detect      (core_detect),
    .peak_offset (core_offset),
    .peak_level  (core_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_detect <= core_detect;
      out_offset <= core_offset;
      out_level  <= core_level;
    end
  end

  assign results.valid       = out_valid;
  assign results.detect      = out_detect;
  assign results.peak_offset = out_offset;
  assign results.peak_level  = out_level;

`ifndef ASSERT_OFF
  // every sample leaving the input stage shows up as a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    advance |=> results.valid)
    else $error("result missing after input stage advanced");

  // both stages full and the result stalled: no new request taken
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && results.valid && !results.ready) |-> !samples.ready)
    else $error("request taken with both stages full");

  // no detection means cleared peak fields
  assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.detect) |->
      (results.peak_offset == '0 && results.peak_level == '0))
    else $error("peak fields nonzero without detect");

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    ($past(results.valid && !results.ready) && !$past(rst)) |->
      (results.valid && $stable(results.detect) && $stable(results.peak_offset)))
    else $error("stalled result changed");
`endif

endmodule

// ===== sim/tpd_detect_checker.sv =====
`timescale 1ns / 1ps
// tpd_detect_checker: watches the sample, result and cfg channels, predicts each result
// depends on tpd_pkg; instantiated by tb_threshold_peak_detector_holdoff

module tpd_detect_checker #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 smp_valid,
  input  logic                                 smp_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       smp_sample,
  input  logic                                 res_valid,
  input  logic                                 res_ready,
  input  logic                                 res_detect,
  input  logic        [COUNT_WIDTH-1:0]        res_offset,
  input  logic signed [SAMPLE_WIDTH-1:0]       res_level,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [tpd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tpd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   result_count,
  output int                                   detect_count
);

  typedef struct packed {
    logic                           detect;
    logic        [COUNT_WIDTH-1:0]  peak_offset;
    logic signed [SAMPLE_WIDTH-1:0] peak_level;
  } peak_report_t;

  localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [tpd_pkg::THRESHOLD_WIDTH-1:0] level_thr;
  logic [tpd_pkg::LIMIT_WIDTH-1:0]     hold_limit;
  logic [tpd_pkg::MODE_WIDTH-1:0]      det_mode;
  logic signed [SAMPLE_WIDTH-1:0]      peak_value;
  logic [COUNT_WIDTH-1:0]              peak_age;
  logic [COUNT_WIDTH-1:0]              hold_count;
  peak_report_t                        peak_reports[$];
  int                                  fails = 0;
  int                                  results_seen = 0;
  int                                  detects_seen = 0;

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    detect_count = 0;
  end

  // one sample through the idle / tracking / holdoff machine
  task automatic step_peak_search(input logic signed [SAMPLE_WIDTH-1:0] s,
                                  output peak_report_t r);
    logic   above;
    logic   done;
    longint lim_eff;
    r       = '0;
    above   = int'(s) > -int'(level_thr);
    lim_eff = (longint'(hold_limit) > COUNT_MAX) ? COUNT_MAX : longint'(hold_limit);
    done    = 1'b0;
    if (det_mode != tpd_pkg::MODE_TRACK && det_mode != tpd_pkg::MODE_HOLD) begin
      det_mode = tpd_pkg::MODE_IDLE;
    end
    if (det_mode != tpd_pkg::MODE_IDLE && peak_age != '1) peak_age = peak_age + 1'b1;
    while (!done) begin
      if (det_mode == tpd_pkg::MODE_IDLE) begin
        if (above) det_mode = tpd_pkg::MODE_TRACK;
        else done = 1'b1;
      end else if (det_mode == tpd_pkg::MODE_TRACK) begin
        if (s > peak_value) begin
          peak_value = s;
          peak_age   = '0;
          done       = 1'b1;
        end else if (above) begin
          done = 1'b1;
        end else begin
          det_mode = tpd_pkg::MODE_HOLD;
        end
      end else begin
        if (above) begin
          det_mode   = tpd_pkg::MODE_TRACK;
          hold_count = '0;
        end else if (longint'(hold_count) < lim_eff) begin
          hold_count = hold_count + 1'b1;
          done       = 1'b1;
        end else begin
          r.detect      = 1'b1;
          r.peak_offset = peak_age;
          r.peak_level  = peak_value;
          hold_count    = '0;
          peak_value    = SAMPLE_MIN;
          peak_age      = '0;
          det_mode      = tpd_pkg::MODE_IDLE;
          done          = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    peak_report_t want;
    peak_report_t next_req;
    if (rst) begin
      level_thr  = '0;
      hold_limit = tpd_pkg::HOLDOFF_LIMIT_RESET;
      det_mode   = tpd_pkg::MODE_IDLE;
      peak_value = SAMPLE_MIN;
      peak_age   = '0;
      hold_count = '0;
      peak_reports.delete();
    end else begin
      // results leave through the input and result registers after their sample, so compare before queuing
      if (res_valid && res_ready) begin
        results_seen++;
        if (res_detect === 1'b1) detects_seen++;
        if (peak_reports.size() == 0) begin
          $error("result with no outstanding request: detect %0b, peak_offset %0d",
                 res_detect, res_offset);
          fails++;
        end else begin
          want = peak_reports.pop_front();
          if (want.detect !== res_detect) begin
            $error("detect mismatch: expected %0b, actual %0b", want.detect, res_detect);
            fails++;
          end
          if (want.peak_offset !== res_offset) begin
            $error("peak_offset mismatch: expected %0d, actual %0d",
                   want.peak_offset, res_offset);
            fails++;
          end
          if (want.peak_level !== res_level) begin
            $error("peak_level mismatch: expected %0d, actual %0d",
                   want.peak_level, res_level);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tpd_pkg::CFG_THRESHOLD) begin
          level_thr = cfg_data[tpd_pkg::THRESHOLD_WIDTH-1:0];
        end else if (cfg_index == tpd_pkg::CFG_HOLDOFF_LIMIT) begin
          hold_limit = cfg_data[tpd_pkg::LIMIT_WIDTH-1:0];
        end
      end
      if (smp_valid && smp_ready) begin
        step_peak_search(smp_sample, next_req);
        peak_reports.push_back(next_req);
      end
    end
    fail_count   <= fails;
    pending      <= peak_reports.size();
    result_count <= results_seen;
    detect_count <= detects_seen;
  end

endmodule

// ===== sim/tb_threshold_peak_detector_holdoff.sv =====
`timescale 1ns / 1ps
// tb_threshold_peak_detector_holdoff: stimulus, idling and verdict for the peak detector
// depends on tpd_pkg, tpd_if, threshold_peak_detector_holdoff and tpd_detect_checker

module tb_threshold_peak_detector_holdoff;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COUNT_WIDTH     = 16;
  localparam int DATA_WIDTH      = tpd_pkg::CFG_DATA_WIDTH;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 200;
  // two register stages, plus margin
  localparam int DRAIN_CYCLES    = 4;
  localparam int PRESSURE_CYCLES = 400;
  localparam int QUIET_LIMIT     = 5000;
  // pulse and holdoff length in the largest-settings run
  localparam int AGE_RUN         = 40;

  // indexes that name no register
  localparam logic [tpd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [tpd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED_HI = 2'd3;

  typedef enum int {IDLING_NONE, IDLING_SENDER, IDLING_RECEIVER, IDLING_BOTH} idling_t;

  logic clk;
  logic rst;

  tpd_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples_ch ();
  tpd_result_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) results_ch ();
  tpd_cfg_if cfg_ch ();

  int   fail_count;
  int   pending;
  int   result_count;
  int   detect_count;
  int   sent_count = 0;
  int   settings_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  logic hold_off_req = 1'b0;
  int   quiet_cycles = 0;
  int   cur_thr = 0;
  int   cur_lim = int'(tpd_pkg::HOLDOFF_LIMIT_RESET);

  threshold_peak_detector_holdoff #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .results(results_ch),
    .cfg    (cfg_ch)
  );

  tpd_detect_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .smp_valid   (samples_ch.valid),
    .smp_ready   (samples_ch.ready),
    .smp_sample  (samples_ch.sample),
    .res_valid   (results_ch.valid),
    .res_ready   (results_ch.ready),
    .res_detect  (results_ch.detect),
    .res_offset  (results_ch.peak_offset),
    .res_level   (results_ch.peak_level),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count),
    .detect_count(detect_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request so the
  // input stage fills and the block pushes back on the sender
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = PRESSURE_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("threshold_peak_detector_holdoff verification failed");
        $finish;
      end
    end
  end

  // one sample request; the sender may idle first, valid stays up until taken
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(negedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= s;
    do @(posedge clk); while (!(samples_ch.valid && samples_ch.ready));
    sent_count++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [tpd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [tpd_pkg::CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // both registers; keeps the masked values to steer the sample generator
  task automatic set_config(input logic [tpd_pkg::CFG_DATA_WIDTH-1:0] thr_data,
                            input logic [tpd_pkg::CFG_DATA_WIDTH-1:0] lim);
    write_reg(tpd_pkg::CFG_THRESHOLD, thr_data);
    write_reg(tpd_pkg::CFG_HOLDOFF_LIMIT, lim);
    cur_thr = int'(thr_data[tpd_pkg::THRESHOLD_WIDTH-1:0]);
    cur_lim = int'(lim);
    settings_count++;
  endtask

  // every expected result in, then the pipeline latency before touching cfg
  task automatic wait_drained();
    stop_sending();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_idling(input idling_t m);
    idle_pct  = (m == IDLING_SENDER) ? 85 : (m == IDLING_BOTH) ? 27 : 0;
    stall_pct = (m == IDLING_RECEIVER) ? 85 : (m == IDLING_BOTH) ? 27 : 0;
  endtask

  // at or below -thr; the boundary itself now and then
  function automatic logic signed [SAMPLE_WIDTH-1:0] below_level(input int thr);
    if ($urandom_range(9) == 0) return SAMPLE_WIDTH'(-thr);
    return SAMPLE_WIDTH'(-32768 + int'($urandom_range(32768 - thr)));
  endfunction

  // strictly above -thr; the first value past the boundary now and then
  function automatic logic signed [SAMPLE_WIDTH-1:0] above_level(input int thr);
    if ($urandom_range(9) == 0) return SAMPLE_WIDTH'(1 - thr);
    return SAMPLE_WIDTH'(1 - thr + int'($urandom_range(32766 + thr)));
  endfunction

  // quiet samples, a pulse, then a holdoff run just around the limit (capped for large
  // limits) with the odd sidelobe thrown in
  task automatic send_burst(input int thr, input int lim);
    int hold_n;
    repeat ($urandom_range(3)) send_sample(below_level(thr));
    repeat ($urandom_range(6, 1)) send_sample(above_level(thr));
    hold_n = ((lim > 30) ? 30 : lim) + int'($urandom_range(3));
    repeat (hold_n) begin
      if ($urandom_range(9) == 0) send_sample(above_level(thr));
      else send_sample(below_level(thr));
    end
  endtask

  initial begin
    int     p;
    int     phase_start;
    logic   pressed;
    idling_t phase_idling;

    rst               = 1'b1;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    apply_idling(IDLING_NONE);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero threshold, long holdoff; zero itself is below level
    send_sample(SAMPLE_WIDTH'(-32768));
    send_sample(SAMPLE_WIDTH'(0));
    send_sample(SAMPLE_WIDTH'(1));
    send_sample(SAMPLE_WIDTH'(32767));
    send_sample(SAMPLE_WIDTH'(-32768));
    wait_drained();

    // threshold 100 written with bit 15 set, which must be dropped; zero holdoff
    set_config(16'h8064, 16'd0);
    send_sample(SAMPLE_WIDTH'(-100));    // exactly at -threshold counts as below
    send_sample(SAMPLE_WIDTH'(-99));     // just above level starts tracking
    send_sample(SAMPLE_WIDTH'(-32768));  // fall with zero holdoff declares at once
    send_sample(SAMPLE_WIDTH'(-101));
    send_sample(SAMPLE_WIDTH'(5));
    send_sample(SAMPLE_WIDTH'(10));
    send_sample(SAMPLE_WIDTH'(7));
    send_sample(SAMPLE_WIDTH'(-200));
    wait_drained();

    // unused register indexes must not disturb anything
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_HI, 16'h0000);
    write_reg(tpd_pkg::CFG_HOLDOFF_LIMIT, 16'd2);
    cur_lim = 2;
    send_sample(SAMPLE_WIDTH'(50));
    send_sample(SAMPLE_WIDTH'(60));
    send_sample(SAMPLE_WIDTH'(-150));    // into holdoff
    send_sample(SAMPLE_WIDTH'(-100));
    send_sample(SAMPLE_WIDTH'(0));       // sidelobe back to tracking, old peak kept
    send_sample(SAMPLE_WIDTH'(70));
    send_sample(SAMPLE_WIDTH'(-300));
    send_sample(SAMPLE_WIDTH'(-300));
    send_sample(SAMPLE_WIDTH'(-300));    // holdoff expired: detect
    send_sample(SAMPLE_WIDTH'(32767));
    send_sample(SAMPLE_WIDTH'(-32768));
    send_sample(SAMPLE_WIDTH'(-32768));
    send_sample(SAMPLE_WIDTH'(-32768));
    wait_drained();

    // largest threshold and holdoff limit: a pulse, then a holdoff that
    // keeps running without expiring
    set_config(16'h7FFF, 16'hFFFF);
    send_sample(SAMPLE_WIDTH'(32767));
    repeat (AGE_RUN) send_sample(above_level(cur_thr));
    repeat (AGE_RUN) send_sample(below_level(cur_thr));
    wait_drained();

    // random phases: each with its own settings and one of the idling patterns
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(16'd1000, 16'd3);
        1: set_config(16'd0, 16'd0);
        2: set_config(16'hFFFF, 16'd8);
        3: begin
          write_reg(CFG_UNUSED_HI, DATA_WIDTH'($urandom));
          set_config(DATA_WIDTH'($urandom), 16'd1);
        end
        4: set_config(16'd20000, DATA_WIDTH'($urandom_range(15)));
        default: set_config(DATA_WIDTH'($urandom), 16'hFFFF);
      endcase
      case (p % 4)
        0: phase_idling = IDLING_NONE;
        1: phase_idling = IDLING_SENDER;
        2: phase_idling = IDLING_RECEIVER;
        default: phase_idling = IDLING_BOTH;
      endcase
      if (p == 5) phase_idling = IDLING_RECEIVER;
      apply_idling(phase_idling);
      phase_start = sent_count;
      pressed     = 1'b0;
      while (sent_count - phase_start < ITEMS_PER_PHASE) begin
        // long receiver hold-off while the sender keeps pushing
        if (p == 2 && !pressed && sent_count - phase_start >= 40) begin
          hold_off_req = 1'b1;
          pressed      = 1'b1;
        end
        if ($urandom_range(99) < 15) send_sample(SAMPLE_WIDTH'($urandom));
        else send_burst(cur_thr, cur_lim);
      end
      wait_drained();
    end

    $display("run covered %0d sample requests under %0d register settings",
             sent_count, settings_count);
    $display("%0d results compared, %0d of them peak detections", result_count, detect_count);
    if (fail_count == 0) begin
      $display("threshold_peak_detector_holdoff verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("threshold_peak_detector_holdoff verification failed");
    end
    $finish;
  end

endmodule
